>>> rtl/plofm_pkg.sv
// ----------------------------------------------------------------------------
// plofm_pkg
// Shared widths, codes and record types for the price-level order matcher.
// ----------------------------------------------------------------------------
package plofm_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 32;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned QTY_W   = 32;
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned TOTAL_W = 38;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_MATCH  = 2'd2,
        REQ_NOP    = 2'd3
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK       = 2'd0,
        KIND_TRADE     = 2'd1,
        KIND_FULL      = 2'd2,
        KIND_NOT_FOUND = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        Q_HOLD,
        Q_APPEND,
        Q_COMPARE,
        Q_REMOVE,
        Q_POP,
        Q_HEAD_SUB
    } q_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_MATCH,
        ST_REPLY,
        ST_READ,
        ST_LOAD
    } ctl_state_t;

    typedef struct packed {
        q_op_t             op;
        logic [ID_W-1:0]   id;
        logic [QTY_W-1:0]  qty;
    } q_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    maker_id;
        logic               maker_status;
        logic               taker_status;
        logic [QTY_W-1:0]   fill_qty;
        logic [TOTAL_W-1:0] qty_processed;
    } trade_rec_t;

    typedef struct packed {
        result_kind_t       kind;
        logic [ID_W-1:0]    maker_id;
        logic [ID_W-1:0]    taker_ref;
        logic               maker_status;
        logic               taker_status;
        logic [QTY_W-1:0]   fill_qty;
        logic [PRICE_W-1:0] trade_price;
        logic [TOTAL_W-1:0] qty_processed;
        logic [TOTAL_W-1:0] total_qty;
        logic [COUNT_W-1:0] order_count;
        logic               last;
    } out_beat_t;

endpackage

>>> rtl/plofm_cell.sv
// ----------------------------------------------------------------------------
// plofm_cell
// One queue slot: order id and remaining quantity, loads on append, takes its
// right neighbor on a shift, and flags an id match for a remove.
// ----------------------------------------------------------------------------
module plofm_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 6
) (
    input  logic                          aclk,
    input  plofm_pkg::q_cmd_t             cmd,
    input  logic [CNT_W-1:0]              count,
    input  logic                          shift_en,
    input  logic [plofm_pkg::ID_W-1:0]    nbr_id,
    input  logic [plofm_pkg::QTY_W-1:0]   nbr_qty,
    output logic [plofm_pkg::ID_W-1:0]    id,
    output logic [plofm_pkg::QTY_W-1:0]   qty,
    output logic                          flag
);
    import plofm_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ID_W-1:0]  id_reg, id_next;
    logic [QTY_W-1:0] qty_reg, qty_next;
    logic             flag_reg, flag_next;

    always_comb begin
        id_next   = id_reg;
        qty_next  = qty_reg;
        flag_next = flag_reg;
        unique case (cmd.op)
            Q_APPEND: begin
                if (count == MY_IDX) begin
                    id_next  = cmd.id;
                    qty_next = cmd.qty;
                end
            end
            Q_COMPARE: begin
                flag_next = (MY_IDX < count) && (id_reg == cmd.id);
            end
            Q_REMOVE, Q_POP: begin
                if (shift_en) begin
                    id_next  = nbr_id;
                    qty_next = nbr_qty;
                end
            end
            Q_HEAD_SUB: begin
                if (IDX == 0) begin
                    qty_next = qty_reg - cmd.qty;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        qty_reg  <= qty_next;
        flag_reg <= flag_next;
    end

    assign id   = id_reg;
    assign qty  = qty_reg;
    assign flag = flag_reg;

endmodule

>>> rtl/plofm_queue.sv
// ----------------------------------------------------------------------------
// plofm_queue
// Row of slot cells, head at cell 0, with resting count and resting total.
// Remove shifts every cell at or past the oldest matching id.
// ----------------------------------------------------------------------------
module plofm_queue #(
    parameter int unsigned QUEUE_DEPTH = plofm_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  plofm_pkg::q_cmd_t              cmd,
    output logic [CNT_W-1:0]               count,
    output logic [plofm_pkg::TOTAL_W-1:0]  total,
    output logic [plofm_pkg::ID_W-1:0]     head_id,
    output logic [plofm_pkg::QTY_W-1:0]    head_qty,
    output logic                           found
);
    import plofm_pkg::*;

    localparam int unsigned LV = $clog2(QUEUE_DEPTH);

    logic [ID_W-1:0]        id_w      [QUEUE_DEPTH];
    logic [QTY_W-1:0]       qty_w     [QUEUE_DEPTH];
    logic [ID_W-1:0]        nbr_id_w  [QUEUE_DEPTH];
    logic [QTY_W-1:0]       nbr_qty_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] flag_w;
    logic [QUEUE_DEPTH-1:0] pre       [LV+1];
    logic [QUEUE_DEPTH-1:0] first_w;
    logic [QUEUE_DEPTH-1:0] shift_w;
    logic [QTY_W-1:0]       removed_qty;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g < QUEUE_DEPTH - 1) begin : g_nbr
            assign nbr_id_w[g]  = id_w[g+1];
            assign nbr_qty_w[g] = qty_w[g+1];
        end else begin : g_end
            assign nbr_id_w[g]  = '0;
            assign nbr_qty_w[g] = '0;
        end

        plofm_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .count    (count_reg),
            .shift_en (shift_w[g]),
            .nbr_id   (nbr_id_w[g]),
            .nbr_qty  (nbr_qty_w[g]),
            .id       (id_w[g]),
            .qty      (qty_w[g]),
            .flag     (flag_w[g])
        );
    end

    // log-depth prefix OR of the match flags
    always_comb begin
        pre[0] = flag_w;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pre[l+1][i] = pre[l][i] | pre[l][i-(1 << l)];
                end else begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    assign first_w = flag_w & ~(pre[LV] << 1);
    assign found   = |flag_w;
    assign shift_w = (cmd.op == Q_POP) ? '1 : pre[LV];

    always_comb begin
        removed_qty = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            removed_qty = removed_qty | (first_w[i] ? qty_w[i] : '0);
        end
    end

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        unique case (cmd.op)
            Q_APPEND: begin
                count_next = count_reg + CNT_W'(1);
                total_next = total_reg + TOTAL_W'(cmd.qty);
            end
            Q_REMOVE: begin
                if (found) begin
                    count_next = count_reg - CNT_W'(1);
                    total_next = total_reg - TOTAL_W'(removed_qty);
                end
            end
            Q_POP: begin
                count_next = count_reg - CNT_W'(1);
                total_next = total_reg - TOTAL_W'(qty_w[0]);
            end
            Q_HEAD_SUB: begin
                total_next = total_reg - TOTAL_W'(cmd.qty);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    assign count    = count_reg;
    assign total    = total_reg;
    assign head_id  = id_w[0];
    assign head_qty = qty_w[0];

endmodule

>>> rtl/plofm_trade_buf.sv
// ----------------------------------------------------------------------------
// plofm_trade_buf
// Holds the trades of one match until the final totals are known, then plays
// them back in order with a registered read.
// ----------------------------------------------------------------------------
module plofm_trade_buf #(
    parameter int unsigned QUEUE_DEPTH = plofm_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    clear,
    input  logic                    wr_en,
    input  plofm_pkg::trade_rec_t   wr_rec,
    input  logic                    rd_en,
    output plofm_pkg::trade_rec_t   rd_rec,
    output logic                    rd_last
);
    import plofm_pkg::*;

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    trade_rec_t       mem [QUEUE_DEPTH];
    trade_rec_t       rd_rec_reg;
    logic             rd_last_reg;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (clear) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
        end else begin
            if (wr_en) begin
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
            end
            if (rd_en) begin
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg[IDX_W-1:0]] <= wr_rec;
        end
        if (rd_en) begin
            rd_rec_reg  <= mem[rd_ptr_reg[IDX_W-1:0]];
            rd_last_reg <= (rd_ptr_reg + CNT_W'(1)) == wr_ptr_reg;
        end
    end

    assign rd_rec  = rd_rec_reg;
    assign rd_last = rd_last_reg;

endmodule

>>> rtl/price_level_order_fifo_matcher.sv
// ----------------------------------------------------------------------------
// price_level_order_fifo_matcher
// FIFO of resting orders at one price level with append, remove by id and
// taker matching against the head.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_wr_en          cfg_wr_data (level price)
//   s_        in         s_valid/s_ready    req_type, order_id, qty, taker_id
//   m_        out        m_valid/m_ready    one result beat, m_last on final
//
// Append, nop and an empty match go straight to the reply; remove first compares ids
// and then shifts. A match pops or trims the head once per maker in the cell row, then
// reads each beat back from the trade buffer through the read and load states.
// A new request is taken while the previous final beat waits in the output
// register; a stalled m_ready holds the sequencer before its next beat.
// Reset is synchronous; the queue comes up empty with no clearing pass.
// ----------------------------------------------------------------------------
module price_level_order_fifo_matcher #(
    parameter int unsigned QUEUE_DEPTH = plofm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [plofm_pkg::PRICE_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plofm_pkg::REQ_W-1:0]    s_req_type,
    input  logic [plofm_pkg::ID_W-1:0]     s_order_id,
    input  logic [plofm_pkg::QTY_W-1:0]    s_qty,
    input  logic [plofm_pkg::ID_W-1:0]     s_taker_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [plofm_pkg::KIND_W-1:0]   m_result_kind,
    output logic [plofm_pkg::ID_W-1:0]     m_maker_id,
    output logic [plofm_pkg::ID_W-1:0]     m_taker_ref,
    output logic                           m_maker_status,
    output logic                           m_taker_status,
    output logic [plofm_pkg::QTY_W-1:0]    m_fill_qty,
    output logic [plofm_pkg::PRICE_W-1:0]  m_trade_price,
    output logic [plofm_pkg::TOTAL_W-1:0]  m_qty_processed,
    output logic [plofm_pkg::TOTAL_W-1:0]  m_total_qty,
    output logic [plofm_pkg::COUNT_W-1:0]  m_order_count,
    output logic                           m_last
);
    import plofm_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctl_state_t         state_reg, state_next;
    logic [PRICE_W-1:0] level_price_reg, level_price_next;
    logic               m_valid_reg, m_valid_next;
    out_beat_t          out_reg, out_next;
    logic [ID_W-1:0]    taker_reg, taker_next;
    logic [QTY_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0] proc_reg, proc_next;
    result_kind_t       kind_reg, kind_next;
    logic               tstat_reg, tstat_next;

    q_cmd_t             q_cmd;
    logic [CNT_W-1:0]   q_count;
    logic [TOTAL_W-1:0] q_total;
    logic [ID_W-1:0]    q_head_id;
    logic [QTY_W-1:0]   q_head_qty;
    logic               q_found;

    logic               buf_clear;
    logic               buf_wr_en;
    trade_rec_t         buf_wr_rec;
    logic               buf_rd_en;
    trade_rec_t         buf_rd_rec;
    logic               buf_rd_last;

    logic               slot_free;
    req_type_t          s_req;

    plofm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (q_cmd),
        .count    (q_count),
        .total    (q_total),
        .head_id  (q_head_id),
        .head_qty (q_head_qty),
        .found    (q_found)
    );

    plofm_trade_buf #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_trade_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (buf_clear),
        .wr_en   (buf_wr_en),
        .wr_rec  (buf_wr_rec),
        .rd_en   (buf_rd_en),
        .rd_rec  (buf_rd_rec),
        .rd_last (buf_rd_last)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign s_req     = req_type_t'(s_req_type);

    always_comb begin
        state_next       = state_reg;
        level_price_next = cfg_wr_en ? cfg_wr_data : level_price_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        out_next         = out_reg;
        taker_next       = taker_reg;
        rem_next         = rem_reg;
        proc_next        = proc_reg;
        kind_next        = kind_reg;
        tstat_next       = tstat_reg;
        q_cmd            = '{op: Q_HOLD, id: '0, qty: '0};
        buf_clear        = 1'b0;
        buf_wr_en        = 1'b0;
        buf_wr_rec       = '0;
        buf_rd_en        = 1'b0;
        s_ready          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    taker_next = (s_req == REQ_MATCH) ? s_taker_id : '0;
                    rem_next   = s_qty;
                    proc_next  = '0;
                    kind_next  = KIND_ACK;
                    tstat_next = 1'b0;
                    unique case (s_req)
                        REQ_APPEND: begin
                            if (q_count == CNT_W'(QUEUE_DEPTH)) begin
                                kind_next = KIND_FULL;
                            end else begin
                                q_cmd = '{op: Q_APPEND, id: s_order_id, qty: s_qty};
                            end
                            state_next = ST_REPLY;
                        end
                        REQ_REMOVE: begin
                            q_cmd      = '{op: Q_COMPARE, id: s_order_id, qty: '0};
                            state_next = ST_REMOVE;
                        end
                        REQ_MATCH: begin
                            if (q_count == '0 || s_qty == '0) begin
                                tstat_next = (s_qty == '0);
                                state_next = ST_REPLY;
                            end else begin
                                buf_clear  = 1'b1;
                                state_next = ST_MATCH;
                            end
                        end
                        default: begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                q_cmd      = '{op: Q_REMOVE, id: '0, qty: '0};
                kind_next  = q_found ? KIND_ACK : KIND_NOT_FOUND;
                state_next = ST_REPLY;
            end
            ST_MATCH: begin
                buf_wr_en           = 1'b1;
                buf_wr_rec.maker_id = q_head_id;
                if (rem_reg < q_head_qty) begin
                    q_cmd                    = '{op: Q_HEAD_SUB, id: '0, qty: rem_reg};
                    buf_wr_rec.maker_status  = 1'b0;
                    buf_wr_rec.taker_status  = 1'b1;
                    buf_wr_rec.fill_qty      = rem_reg;
                    buf_wr_rec.qty_processed = proc_reg + TOTAL_W'(rem_reg);
                    state_next               = ST_READ;
                end else begin
                    q_cmd                    = '{op: Q_POP, id: '0, qty: '0};
                    rem_next                 = rem_reg - q_head_qty;
                    buf_wr_rec.maker_status  = 1'b1;
                    buf_wr_rec.taker_status  = (rem_reg == q_head_qty);
                    buf_wr_rec.fill_qty      = q_head_qty;
                    buf_wr_rec.qty_processed = proc_reg + TOTAL_W'(q_head_qty);
                    if (rem_reg == q_head_qty || q_count == CNT_W'(1)) begin
                        state_next = ST_READ;
                    end
                end
                proc_next = buf_wr_rec.qty_processed;
            end
            ST_REPLY: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    out_next     = '{
                        kind:          kind_reg,
                        maker_id:      '0,
                        taker_ref:     taker_reg,
                        maker_status:  1'b0,
                        taker_status:  tstat_reg,
                        fill_qty:      '0,
                        trade_price:   '0,
                        qty_processed: '0,
                        total_qty:     q_total,
                        order_count:   COUNT_W'(q_count),
                        last:          1'b1
                    };
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                buf_rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    out_next     = '{
                        kind:          KIND_TRADE,
                        maker_id:      buf_rd_rec.maker_id,
                        taker_ref:     taker_reg,
                        maker_status:  buf_rd_rec.maker_status,
                        taker_status:  buf_rd_rec.taker_status,
                        fill_qty:      buf_rd_rec.fill_qty,
                        trade_price:   level_price_reg,
                        qty_processed: buf_rd_rec.qty_processed,
                        total_qty:     q_total,
                        order_count:   COUNT_W'(q_count),
                        last:          buf_rd_last
                    };
                    state_next = buf_rd_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            level_price_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            level_price_reg <= level_price_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg   <= out_next;
        taker_reg <= taker_next;
        rem_reg   <= rem_next;
        proc_reg  <= proc_next;
        kind_reg  <= kind_next;
        tstat_reg <= tstat_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_maker_id      = out_reg.maker_id;
    assign m_taker_ref     = out_reg.taker_ref;
    assign m_maker_status  = out_reg.maker_status;
    assign m_taker_status  = out_reg.taker_status;
    assign m_fill_qty      = out_reg.fill_qty;
    assign m_trade_price   = out_reg.trade_price;
    assign m_qty_processed = out_reg.qty_processed;
    assign m_total_qty     = out_reg.total_qty;
    assign m_order_count   = out_reg.order_count;
    assign m_last          = out_reg.last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("resting count above queue depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req == REQ_APPEND && q_count < CNT_W'(QUEUE_DEPTH))
        |=> q_count == $past(q_count) + CNT_W'(1))
        else $error("accepted append did not grow the queue");

    a_match_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MATCH |-> q_count != '0)
        else $error("matching against an empty queue");

    a_partial_maker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_TRADE && !m_maker_status) |-> m_taker_status)
        else $error("partial maker fill left taker open");

    a_simple_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_TRADE) |-> m_last)
        else $error("non-trade beat not marked last");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the price-level order matcher. It drives requests on the s_
// channel and checks every m_ beat against an in-bench model of the resting
// queue. A short directed part comes first, then a fill-and-sweep run, random
// traffic under several level prices, and a long result stall that backs the
// block up. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import plofm_pkg::*;

    localparam int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 10;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [PRICE_W-1:0]  cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [ID_W-1:0]     s_order_id;
    logic [QTY_W-1:0]    s_qty;
    logic [ID_W-1:0]     s_taker_id;
    logic                m_valid;
    logic                m_ready;
    logic [KIND_W-1:0]   m_result_kind;
    logic [ID_W-1:0]     m_maker_id;
    logic [ID_W-1:0]     m_taker_ref;
    logic                m_maker_status;
    logic                m_taker_status;
    logic [QTY_W-1:0]    m_fill_qty;
    logic [PRICE_W-1:0]  m_trade_price;
    logic [TOTAL_W-1:0]  m_qty_processed;
    logic [TOTAL_W-1:0]  m_total_qty;
    logic [COUNT_W-1:0]  m_order_count;
    logic                m_last;

    // resting queue as the block should hold it
    logic [ID_W-1:0]     lvl_id  [QUEUE_DEPTH];
    logic [QTY_W-1:0]    lvl_qty [QUEUE_DEPTH];
    int                  lvl_count;
    logic [TOTAL_W-1:0]  lvl_total;
    logic [PRICE_W-1:0]  lvl_price;

    out_beat_t           expected_beats[$];
    int                  mismatches;
    int                  beats_seen;
    int                  cycle_count;
    bit                  tx_idle;
    bit                  rx_idle;
    int                  rx_wait;
    int                  hold_off_left;

    price_level_order_fifo_matcher #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_order_id      (s_order_id),
        .s_qty           (s_qty),
        .s_taker_id      (s_taker_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_maker_id      (m_maker_id),
        .m_taker_ref     (m_taker_ref),
        .m_maker_status  (m_maker_status),
        .m_taker_status  (m_taker_status),
        .m_fill_qty      (m_fill_qty),
        .m_trade_price   (m_trade_price),
        .m_qty_processed (m_qty_processed),
        .m_total_qty     (m_total_qty),
        .m_order_count   (m_order_count),
        .m_last          (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Level model: applies one request and queues the beats it produces.
    // ------------------------------------------------------------------------
    task automatic apply_level_request(req_type_t rt, logic [ID_W-1:0] oid,
                                       logic [QTY_W-1:0] q, logic [ID_W-1:0] tid);
        out_beat_t          fresh[$];
        out_beat_t          b;
        logic [QTY_W-1:0]   rem;
        logic [QTY_W-1:0]   hq;
        logic [TOTAL_W-1:0] done_qty;
        int                 popped;
        int                 hit;
        b = '0;
        b.kind = KIND_ACK;
        b.last = 1'b1;
        case (rt)
            REQ_APPEND: begin
                if (lvl_count >= QUEUE_DEPTH) begin
                    b.kind = KIND_FULL;
                end else begin
                    lvl_id[lvl_count]  = oid;
                    lvl_qty[lvl_count] = q;
                    lvl_count++;
                    lvl_total = lvl_total + TOTAL_W'(q);
                end
                fresh = {fresh, b};
            end
            REQ_REMOVE: begin
                hit = -1;
                for (int i = 0; i < lvl_count; i++) begin
                    if (hit < 0 && lvl_id[i] == oid) hit = i;
                end
                if (hit < 0) begin
                    b.kind = KIND_NOT_FOUND;
                end else begin
                    lvl_total = lvl_total - TOTAL_W'(lvl_qty[hit]);
                    for (int i = hit; i < lvl_count - 1; i++) begin
                        lvl_id[i]  = lvl_id[i+1];
                        lvl_qty[i] = lvl_qty[i+1];
                    end
                    lvl_count--;
                end
                fresh = {fresh, b};
            end
            REQ_MATCH: begin
                if (lvl_count == 0 || q == '0) begin
                    b.taker_ref    = tid;
                    b.taker_status = (q == '0);
                    fresh = {fresh, b};
                end else begin
                    rem      = q;
                    popped   = 0;
                    done_qty = '0;
                    while (popped < lvl_count && rem != '0) begin
                        b             = '0;
                        b.kind        = KIND_TRADE;
                        b.maker_id    = lvl_id[popped];
                        b.taker_ref   = tid;
                        b.trade_price = lvl_price;
                        hq            = lvl_qty[popped];
                        if (rem < hq) begin
                            lvl_qty[popped] = hq - rem;
                            done_qty        = done_qty + TOTAL_W'(rem);
                            lvl_total       = lvl_total - TOTAL_W'(rem);
                            b.taker_status  = 1'b1;
                            b.fill_qty      = rem;
                            rem             = '0;
                        end else begin
                            rem            = rem - hq;
                            done_qty       = done_qty + TOTAL_W'(hq);
                            lvl_total      = lvl_total - TOTAL_W'(hq);
                            popped++;
                            b.maker_status = 1'b1;
                            b.taker_status = (rem == '0);
                            b.fill_qty     = hq;
                        end
                        b.qty_processed = done_qty;
                        fresh = {fresh, b};
                    end
                    for (int i = 0; i < lvl_count - popped; i++) begin
                        lvl_id[i]  = lvl_id[i+popped];
                        lvl_qty[i] = lvl_qty[i+popped];
                    end
                    lvl_count -= popped;
                    fresh[fresh.size()-1].last = 1'b1;
                end
            end
            default: fresh = {fresh, b};
        endcase
        foreach (fresh[k]) begin
            fresh[k].total_qty   = lvl_total;
            fresh[k].order_count = COUNT_W'(lvl_count);
            expected_beats = {expected_beats, fresh[k]};
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver and result checker
    // ------------------------------------------------------------------------
    task automatic send_request(req_type_t rt, logic [ID_W-1:0] oid,
                                logic [QTY_W-1:0] q, logic [ID_W-1:0] tid);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_order_id <= oid;
        s_qty      <= q;
        s_taker_id <= tid;
        do @(posedge aclk); while (!s_ready);
        apply_level_request(rt, oid, q, tid);
    endtask

    task automatic wait_level_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_level_price(logic [PRICE_W-1:0] price);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= price;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        lvl_price = price;
    endtask

    function automatic string beat_text(out_beat_t b);
        return $sformatf({"kind=%0d maker=%h taker=%h ms=%b ts=%b fill=%h ",
                          "price=%h proc=%h total=%h cnt=%0d last=%b"},
                         b.kind, b.maker_id, b.taker_ref, b.maker_status,
                         b.taker_status, b.fill_qty, b.trade_price,
                         b.qty_processed, b.total_qty, b.order_count, b.last);
    endfunction

    task automatic check_result_beat();
        out_beat_t got;
        out_beat_t want;
        got.kind          = result_kind_t'(m_result_kind);
        got.maker_id      = m_maker_id;
        got.taker_ref     = m_taker_ref;
        got.maker_status  = m_maker_status;
        got.taker_status  = m_taker_status;
        got.fill_qty      = m_fill_qty;
        got.trade_price   = m_trade_price;
        got.qty_processed = m_qty_processed;
        got.total_qty     = m_total_qty;
        got.order_count   = m_order_count;
        got.last          = m_last;
        beats_seen++;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("beat %0d with nothing expected: %s", beats_seen, beat_text(got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.maker_id !== want.maker_id
                || got.taker_ref !== want.taker_ref
                || got.maker_status !== want.maker_status
                || got.taker_status !== want.taker_status
                || got.fill_qty !== want.fill_qty
                || got.trade_price !== want.trade_price
                || got.qty_processed !== want.qty_processed
                || got.total_qty !== want.total_qty
                || got.order_count !== want.order_count
                || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("beat %0d mismatch", beats_seen);
                $display("  expected %s", beat_text(want));
                $display("  actual   %s", beat_text(got));
            end
        end
    endtask

    initial begin : result_monitor
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result_beat();
                rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
            end
            @(negedge aclk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic send_random_request();
        req_type_t        rt;
        logic [ID_W-1:0]  oid;
        logic [QTY_W-1:0] q;
        int               pick;
        pick = $urandom_range(0, 99);
        oid  = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
        q    = ($urandom_range(0, 3) == 0) ? QTY_W'($urandom) : QTY_W'($urandom_range(0, 40));
        if (pick < 42) begin
            rt = REQ_APPEND;
        end else if (pick < 62) begin
            rt = REQ_REMOVE;
            if (lvl_count > 0 && $urandom_range(0, 3) != 0)
                oid = lvl_id[$urandom_range(0, lvl_count - 1)];
        end else if (pick < 95) begin
            rt = REQ_MATCH;
            case ($urandom_range(0, 5))
                0: q = $urandom;
                1: q = '0;
                2: q = (lvl_total > TOTAL_W'(32'hFFFF_FFFF)) ? '1 : lvl_total[QTY_W-1:0];
                default: q = $urandom_range(1, 120);
            endcase
        end else begin
            rt = REQ_NOP;
        end
        send_request(rt, oid, q, $urandom);
    endtask

    // empty-queue cases, duplicates, zero-quantity makers, partial and exact fills
    task automatic test_directed_cases();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(REQ_MATCH,  '0, 32'd5, '1);
        send_request(REQ_MATCH,  '0, '0, 32'h1234_5678);
        send_request(REQ_REMOVE, '0, '0, '0);
        send_request(REQ_NOP,    '1, '1, '1);
        send_request(REQ_APPEND, '1, '1, '0);
        send_request(REQ_APPEND, '0, '0, '0);
        send_request(REQ_APPEND, 32'd7, 32'd10, '0);
        send_request(REQ_APPEND, 32'd7, 32'd20, '0);
        send_request(REQ_APPEND, 32'd9, 32'd1, '0);
        send_request(REQ_REMOVE, 32'd7, '0, '0);
        send_request(REQ_REMOVE, 32'd12345, '0, '0);
        send_request(REQ_MATCH,  '0, '0, 32'd77);
        send_request(REQ_MATCH,  '0, 32'd5, '0);
        send_request(REQ_MATCH,  '0, '1, 32'hA5A5_A5A5);
        send_request(REQ_MATCH,  '0, 32'd16, 32'h5A5A_5A5A);
        send_request(REQ_MATCH,  '0, 32'd3, '1);
        send_request(REQ_APPEND, 32'd3, '0, '0);
        send_request(REQ_MATCH,  '0, 32'd1, 32'd4);
        wait_level_idle();
    endtask

    // fill to depth, overflow, then one taker sweeps every maker
    task automatic test_fill_and_sweep();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        while (lvl_count < QUEUE_DEPTH)
            send_request(REQ_APPEND, $urandom, $urandom_range(0, 1000), '0);
        send_request(REQ_APPEND, $urandom, $urandom, '0);
        send_request(REQ_REMOVE, 32'hDEAD_0000, '0, '0);
        send_request(REQ_APPEND, $urandom, $urandom, '0);
        send_request(REQ_MATCH, '0, '1, $urandom);
        wait_level_idle();
    endtask

    task automatic test_random_traffic(int count, bit tx_gaps, bit rx_gaps);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        repeat (count) send_random_request();
        wait_level_idle();
    endtask

    // result side holds off while requests keep coming
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_off_left = 300;
        repeat (40) send_random_request();
        wait_level_idle();
    endtask

    initial begin : main_sequence
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_req_type  = '0;
        s_order_id  = '0;
        s_qty       = '0;
        s_taker_id  = '0;
        lvl_count   = 0;
        lvl_total   = '0;
        lvl_price   = '0;
        mismatches  = 0;
        beats_seen  = 0;
        rx_wait     = 0;
        hold_off_left = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        write_level_price('1);
        test_fill_and_sweep();
        write_level_price($urandom);
        test_random_traffic(90, 1'b1, 1'b1);
        write_level_price('0);
        test_random_traffic(90, 1'b0, 1'b0);
        write_level_price($urandom);
        test_random_traffic(90, 1'b1, 1'b0);
        write_level_price('1);
        test_output_backpressure();

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
